### design/rrca_pkg.sv
// Package: shared types, codes and sizes of the round-robin capacity assigner.
`timescale 1ns / 1ps
package rrca_pkg;

  // Table size and field widths
  localparam int unsigned MaxTargets = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned CntW       = 5;
  localparam int unsigned CapW       = 8;
  localparam int unsigned ServW      = 32;
  localparam int unsigned ActW       = 3;
  localparam int unsigned StatW      = 3;
  localparam int unsigned EntryW     = CapW + CapW + ServW;

  // Action codes
  localparam logic [ActW-1:0] ActAssign  = 3'd0;
  localparam logic [ActW-1:0] ActRelease = 3'd1;
  localparam logic [ActW-1:0] ActOpen    = 3'd2;
  localparam logic [ActW-1:0] ActClose   = 3'd3;
  localparam logic [ActW-1:0] ActSetCap  = 3'd4;

  // Status codes
  localparam logic [StatW-1:0] StatOk     = 3'd0;
  localparam logic [StatW-1:0] StatNone   = 3'd1;
  localparam logic [StatW-1:0] StatRange  = 3'd2;
  localparam logic [StatW-1:0] StatEmpty  = 3'd3;
  localparam logic [StatW-1:0] StatBadCap = 3'd4;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [IdxW-1:0] target_index;
    logic [CapW-1:0] capacity_value;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdxW-1:0]  chosen_index;
    logic [ServW-1:0] served_total;
    logic [CntW-1:0]  available_count;
  } rsp_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [CapW-1:0]  cap;
    logic [CapW-1:0]  load;
    logic [ServW-1:0] served;
  } entry_t;

endpackage

### design/rrca_req_if.sv
// Interface: request channel (valid, ready, payload).
`timescale 1ns / 1ps
interface rrca_req_if import rrca_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/rrca_rsp_if.sv
// Interface: result channel (valid, ready, payload).
`timescale 1ns / 1ps
interface rrca_rsp_if import rrca_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/rrca_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rrca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/round_robin_capacity_assigner_unit.sv
// Flow: a request is accepted in idle and its entry read; in the execute state the
// entry is modified and the result is registered once the previous one is taken.
// A new request is taken only in idle, after the read-modify-write of the entry
// RAM completes; a result not yet taken holds the unit in the execute state.
// Reset: open flags, headroom and entry-valid bits, pointer and target count
// clear at once; entries that were never written read as zero, no clearing pass.
`timescale 1ns / 1ps
module round_robin_capacity_assigner_unit import rrca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CntW-1:0]  cfg_wdata_i,
  rrca_req_if.sink         req_i,
  rrca_rsp_if.source       rsp_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       tc_q;
  logic [IdxW-1:0]       ptr_q;
  logic [MaxTargets-1:0] open_q, room_q, entry_valid_q;
  logic [MaxTargets-1:0] open_d, room_d, entry_valid_d;
  logic [ActW-1:0]       act_q;
  logic [IdxW-1:0]       idx_q, pick_q;
  logic [CapW-1:0]       capv_q;
  logic                  found_q;
  logic                  rsp_valid_q;
  rsp_t                  rsp_q, rsp_d;

  // Targets in use and scan masks
  logic [CntW-1:0]       n_use;
  logic [MaxTargets-1:0] inuse_mask, usable, hi_mask, cand;
  logic [IdxW-1:0]       start, pick;
  logic                  accept, done;

  assign n_use = (tc_q > CntW'(MaxTargets)) ? CntW'(MaxTargets) : tc_q;
  assign start = ({1'b0, ptr_q} < n_use) ? ptr_q : '0;

  always_comb begin
    for (int i = 0; i < MaxTargets; i++) begin
      inuse_mask[i] = CntW'(i) < n_use;
      hi_mask[i]    = IdxW'(i) >= start;
    end
  end

  assign usable = open_q & room_q & inuse_mask;
  assign cand   = (|(usable & hi_mask)) ? (usable & hi_mask) : usable;

  // Lowest set bit of the rotated candidate set
  always_comb begin
    pick = '0;
    for (int i = MaxTargets - 1; i >= 0; i--) begin
      if (cand[i]) pick = IdxW'(i);
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign done        = (state_q == StExec) && (!rsp_valid_q || rsp_o.ready);

  // Entry RAM: capacity, load and served count
  logic [IdxW-1:0]   raddr, addr_x;
  logic [EntryW-1:0] rdata;
  entry_t            ent, ent_new;
  logic              we;

  assign raddr = (req_i.data.action == ActAssign) ? pick : req_i.data.target_index;

  rrca_ram #(
    .Width (EntryW),
    .Depth (MaxTargets)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_x),
    .wdata_i (ent_new),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Execute state: modify the entry and build the result
  logic            in_range;
  logic [CntW-1:0] avail;

  assign addr_x   = (act_q == ActAssign) ? pick_q : idx_q;
  assign ent      = entry_valid_q[addr_x] ? entry_t'(rdata) : '0;
  assign in_range = {1'b0, idx_q} < n_use;

  always_comb begin
    ent_new             = ent;
    we                  = 1'b0;
    open_d              = open_q;
    room_d              = room_q;
    entry_valid_d       = entry_valid_q;
    rsp_d.status        = StatOk;
    rsp_d.chosen_index  = idx_q;
    rsp_d.served_total  = '0;

    case (act_q)
      ActAssign: begin
        rsp_d.chosen_index = '0;
        if (found_q) begin
          ent_new.load = ent.load + CapW'(1);
          if (ent.served != '1) ent_new.served = ent.served + ServW'(1);
          we                 = 1'b1;
          rsp_d.chosen_index = pick_q;
          rsp_d.served_total = ent_new.served;
        end else begin
          rsp_d.status = StatNone;
        end
      end
      ActRelease, ActOpen, ActClose, ActSetCap: begin
        if (!in_range) begin
          rsp_d.status = StatRange;
        end else begin
          rsp_d.served_total = ent.served;
          case (act_q)
            ActRelease: begin
              if (ent.load == '0) begin
                rsp_d.status = StatEmpty;
              end else begin
                ent_new.load = ent.load - CapW'(1);
                we           = 1'b1;
              end
            end
            ActOpen:  open_d[idx_q] = 1'b1;
            ActClose: open_d[idx_q] = 1'b0;
            default: begin
              if (capv_q == '0) begin
                rsp_d.status = StatBadCap;
              end else begin
                ent_new            = '{cap: capv_q, load: '0, served: '0};
                we                 = 1'b1;
                rsp_d.served_total = '0;
              end
            end
          endcase
        end
      end
      default: begin
        if (in_range) rsp_d.served_total = ent.served;
      end
    endcase

    if (we) begin
      entry_valid_d[addr_x] = 1'b1;
      room_d[addr_x]        = ent_new.load < ent_new.cap;
    end
    we = we && done;

    // Available count after the step
    avail = '0;
    for (int i = 0; i < MaxTargets; i++) begin
      avail = avail + CntW'(open_d[i] & room_d[i] & inuse_mask[i]);
    end
    rsp_d.available_count = avail;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StExec;
      StExec:  if (done) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control and table flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      tc_q          <= '0;
      ptr_q         <= '0;
      open_q        <= '0;
      room_q        <= '0;
      entry_valid_q <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) tc_q <= cfg_wdata_i;
      if (done) begin
        open_q        <= open_d;
        room_q        <= room_d;
        entry_valid_q <= entry_valid_d;
        rsp_valid_q   <= 1'b1;
        if (act_q == ActAssign && found_q) begin
          ptr_q <= (CntW'(pick_q) + CntW'(1) < n_use) ? pick_q + IdxW'(1) : '0;
        end
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= req_i.data.action;
      idx_q   <= req_i.data.target_index;
      capv_q  <= req_i.data.capacity_value;
      pick_q  <= pick;
      found_q <= |usable;
    end
    if (done) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Assertions
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StExec)
    else $error("accepted request did not move to execute");

  a_room_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (room_q & ~entry_valid_q) == '0)
    else $error("headroom set on an entry never written");

  a_pick_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec && act_q == ActAssign && found_q) |-> (CntW'(pick_q) < n_use))
    else $error("assigned target outside the targets in use");

  a_avail_le_n : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> avail <= n_use)
    else $error("available count exceeds targets in use");

endmodule

### sim/tb_round_robin_capacity_assigner_unit.sv
// Testbench: round-robin capacity assigner checked against a built-in predictor.
`timescale 1ns / 1ps
module tb_round_robin_capacity_assigner_unit import rrca_pkg::*; ();

  // Unknown action codes, answered without any change
  localparam logic [ActW-1:0] ActSpareLo = 3'd5;
  localparam logic [ActW-1:0] ActSpareMid = 3'd6;
  localparam logic [ActW-1:0] ActSpareHi = 3'd7;
  localparam int unsigned PhaseItems = 64;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;

  rrca_req_if req_ch ();
  rrca_rsp_if rsp_ch ();

  round_robin_capacity_assigner_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  // Predictor copy of the target table
  logic             open_q   [MaxTargets];
  logic [CapW-1:0]  cap_q    [MaxTargets];
  logic [CapW-1:0]  load_q   [MaxTargets];
  logic [ServW-1:0] served_q [MaxTargets];
  logic [IdxW-1:0]  rotate_ptr_q;
  logic [CntW-1:0]  target_count_q;

  rsp_t        predicted_answers[$];
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned targets_in_use();
    return (target_count_q > MaxTargets) ? MaxTargets : int'(target_count_q);
  endfunction

  function automatic bit has_room(int unsigned t);
    return open_q[t] && (load_q[t] < cap_q[t]);
  endfunction

  // Apply one request to the predictor table and return the expected answer
  function automatic rsp_t assigner_step(req_t r);
    rsp_t        a;
    int unsigned n;
    int unsigned start;
    int unsigned t;
    int unsigned idx;
    int unsigned avail;
    bit          found;
    n     = targets_in_use();
    idx   = r.target_index;
    found = 1'b0;
    avail = 0;
    a.status       = StatOk;
    a.chosen_index = r.target_index;
    a.served_total = '0;
    if (r.action == ActAssign) begin
      a.chosen_index = '0;
      start = (rotate_ptr_q < n) ? rotate_ptr_q : 0;
      for (int unsigned s = 0; s < n; s++) begin
        t = (start + s) % n;
        if (!found && has_room(t)) begin
          found = 1'b1;
          load_q[t] = load_q[t] + 1'b1;
          if (served_q[t] != '1) served_q[t] = served_q[t] + 1'b1;
          a.served_total = served_q[t];
          a.chosen_index = t[IdxW-1:0];
          rotate_ptr_q   = (t + 1 < n) ? IdxW'(t + 1) : '0;
        end
      end
      if (!found) a.status = StatNone;
    end else if (r.action <= ActSetCap) begin
      if (idx >= n) begin
        a.status = StatRange;
      end else begin
        case (r.action)
          ActRelease: begin
            if (load_q[idx] == '0) a.status = StatEmpty;
            else load_q[idx] = load_q[idx] - 1'b1;
          end
          ActOpen:  open_q[idx] = 1'b1;
          ActClose: open_q[idx] = 1'b0;
          default: begin
            if (r.capacity_value == '0) begin
              a.status = StatBadCap;
            end else begin
              cap_q[idx]    = r.capacity_value;
              load_q[idx]   = '0;
              served_q[idx] = '0;
            end
          end
        endcase
        a.served_total = served_q[idx];
      end
    end else if (idx < n) begin
      a.served_total = served_q[idx];
    end
    for (int unsigned i = 0; i < n; i++) if (has_room(i)) avail++;
    a.available_count = avail[CntW-1:0];
    return a;
  endfunction

  function automatic req_t make_req(logic [ActW-1:0] act, int unsigned idx, int unsigned capv);
    req_t r;
    r.action         = act;
    r.target_index   = idx[IdxW-1:0];
    r.capacity_value = capv[CapW-1:0];
    return r;
  endfunction

  // One request transfer; valid is left high so back-to-back items need no gap
  task automatic send_req(input req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid = 1'b1;
    req_ch.data  = r;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted_answers.push_back(assigner_step(r));
  endtask

  // Drop valid and wait until every answer is back and the unit has settled
  task automatic drain();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (predicted_answers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_target_count(input int unsigned value);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value[CntW-1:0];
    @(negedge clk_i);
    cfg_we_i       = 1'b0;
    target_count_q = value[CntW-1:0];
  endtask

  // Receiver: ready decided once per cycle
  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    rsp_t got_rsp;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got_rsp = rsp_ch.data;
      if (predicted_answers.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: status %0d idx %0d served %0d avail %0d", $time,
                 got_rsp.status, got_rsp.chosen_index, got_rsp.served_total,
                 got_rsp.available_count);
      end else begin
        exp_rsp = predicted_answers.pop_front();
        if (got_rsp.status !== exp_rsp.status ||
            got_rsp.chosen_index !== exp_rsp.chosen_index ||
            got_rsp.served_total !== exp_rsp.served_total ||
            got_rsp.available_count !== exp_rsp.available_count) begin
          mismatch_count++;
          $display("%0t: mismatch: expected status %0d idx %0d served %0d avail %0d", $time,
                   exp_rsp.status, exp_rsp.chosen_index, exp_rsp.served_total,
                   exp_rsp.available_count);
          $display("%0t:           actual   status %0d idx %0d served %0d avail %0d", $time,
                   got_rsp.status, got_rsp.chosen_index, got_rsp.served_total,
                   got_rsp.available_count);
        end
      end
    end
  end

  // Fresh table with no targets in use
  task automatic test_empty_table();
    send_req(make_req(ActAssign, 0, 0));
    send_req(make_req(ActRelease, 0, 0));
    send_req(make_req(ActSpareHi, 15, 255));
  endtask

  // Oversized count, capacity checks, rotation, empty release, unknown actions
  task automatic test_assign_rotation();
    set_target_count(31);
    send_req(make_req(ActSetCap, 15, 255));
    send_req(make_req(ActSetCap, 0, 0));
    send_req(make_req(ActSetCap, 0, 1));
    send_req(make_req(ActAssign, 0, 0));
    send_req(make_req(ActOpen, 0, 0));
    send_req(make_req(ActOpen, 15, 0));
    send_req(make_req(ActAssign, 0, 0));
    send_req(make_req(ActAssign, 0, 0));
    send_req(make_req(ActAssign, 0, 0));
    send_req(make_req(ActRelease, 0, 0));
    send_req(make_req(ActRelease, 0, 0));
    send_req(make_req(ActClose, 15, 0));
    send_req(make_req(ActAssign, 0, 0));
    send_req(make_req(ActSpareLo, 0, 0));
    send_req(make_req(ActSpareMid, 15, 0));
    send_req(make_req(ActSetCap, 0, 2));
  endtask

  // Pointer left beyond a shrunken count restarts the scan at target 0
  task automatic test_stale_pointer();
    send_req(make_req(ActSetCap, 9, 4));
    send_req(make_req(ActOpen, 9, 0));
    send_req(make_req(ActAssign, 0, 0));
    set_target_count(4);
    send_req(make_req(ActSetCap, 1, 1));
    send_req(make_req(ActOpen, 1, 0));
    send_req(make_req(ActAssign, 0, 0));
    send_req(make_req(ActRelease, 9, 0));
  endtask

  function automatic req_t random_req(int unsigned n);
    int unsigned roll;
    int unsigned idx;
    int unsigned capv;
    logic [ActW-1:0] act;
    roll = $urandom_range(99);
    if (roll < 40) act = ActAssign;
    else if (roll < 58) act = ActRelease;
    else if (roll < 70) act = ActOpen;
    else if (roll < 76) act = ActClose;
    else if (roll < 92) act = ActSetCap;
    else act = ActW'($urandom_range(ActSpareHi, ActSpareLo));
    if (n == 0 || $urandom_range(9) == 0) idx = $urandom_range(15);
    else idx = $urandom_range(n - 1);
    case ($urandom_range(9))
      0:       capv = 0;
      1:       capv = $urandom_range(255);
      2:       capv = 255;
      default: capv = $urandom_range(4, 1);
    endcase
    if (act != ActSetCap) capv = $urandom_range(255);
    return make_req(act, idx, capv);
  endfunction

  // Several count settings; each phase brings part of the table up, then mixes traffic
  task automatic test_random_traffic(input int unsigned s_idle, input int unsigned r_idle);
    int unsigned counts[5];
    int unsigned n;
    drain();
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    counts[0] = 16;
    counts[1] = $urandom_range(15, 2);
    counts[2] = 1;
    counts[3] = $urandom_range(31, 17);
    counts[4] = $urandom_range(31);
    foreach (counts[p]) begin
      set_target_count(counts[p]);
      n = targets_in_use();
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(1) == 1) begin
          send_req(make_req(ActSetCap, i, $urandom_range(8, 1)));
          send_req(make_req(ActOpen, i, $urandom_range(255)));
        end
      end
      repeat (PhaseItems) send_req(random_req(n));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    mismatch_count = 0;
    send_idle_pct  = 21;
    recv_idle_pct  = 66;
    rotate_ptr_q   = '0;
    target_count_q = '0;
    for (int i = 0; i < MaxTargets; i++) begin
      open_q[i]   = 1'b0;
      cap_q[i]    = '0;
      load_q[i]   = '0;
      served_q[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_assign_rotation();
    test_stale_pointer();
    test_random_traffic(21, 66);
    test_random_traffic(66, 21);
    test_random_traffic(0, 0);

    drain();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
